>>> rtl/derpe_pkg.sv
package derpe_pkg;

    localparam int unsigned MaxBytes = 11;

    typedef enum logic [2:0] {
        OP_INTEGER = 3'd0,
        OP_BOOLEAN = 3'd1,
        OP_NULL    = 3'd2,
        OP_HEADER  = 3'd3,
        OP_OID_ARC = 3'd4
    } derpe_op_t;

    typedef logic [7:0] derpe_byte_t;
    typedef logic [3:0] derpe_cnt_t;

    localparam derpe_byte_t TAG_BOOLEAN = 8'h01;
    localparam derpe_byte_t TAG_INTEGER = 8'h02;
    localparam derpe_byte_t TAG_NULL    = 8'h05;
    localparam derpe_byte_t LONG_FORM   = 8'h80;
    localparam derpe_byte_t BOOL_TRUE   = 8'hFF;
    localparam derpe_byte_t ZERO_BYTE   = 8'h00;
    localparam derpe_byte_t SEVEN_MASK  = 8'h7F;

endpackage

>>> rtl/der_primitive_encoder.sv
// DER primitive encoder. Each request on the slave stream produces its
// ASN.1 DER bytes on the master stream, one byte per transaction, with
// tlast on the final byte of the request: an INTEGER TLV, a BOOLEAN, a NULL,
// a tag plus definite-length header, or one base-128 OID arc. A request is
// encoded in a single registered pass: it is held in the input register, encoded
// combinationally and loaded into the output shift register once any earlier
// frame has finished; it then sends its bytes (1 to 11) one per transaction.
// The output shift register drains one byte per cycle while m_axis_tready is
// high; the input register takes the next request while the current bytes drain.
// Requests with an unused opcode produce no bytes and are dropped.
module der_primitive_encoder
    import derpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // value[63:0], tag[71:64]
    input  logic [3:0]  s_axis_tuser,   // opcode[2:0], value_signed[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast
);

    logic        in_valid_reg;
    logic [2:0]  in_op_reg;
    logic [63:0] in_value_reg;
    logic        in_signed_reg;
    logic [7:0]  in_tag_reg;

    logic        frm_valid_reg;
    logic        frm_valid_next;
    derpe_cnt_t  frm_cnt_reg;
    derpe_cnt_t  frm_cnt_next;
    derpe_byte_t frm_bytes_reg  [MaxBytes];
    derpe_byte_t frm_bytes_next [MaxBytes];

    derpe_byte_t enc_bytes [MaxBytes];
    derpe_cnt_t  enc_cnt;

    logic        s_fire;
    logic        m_fire;
    logic        frm_done;
    logic        frm_load;
    logic        in_advance;

    derpe_cnt_t  n_uns;
    derpe_cnt_t  n_sgn;
    derpe_cnt_t  n_int;
    logic [63:0] pad_probe;
    logic        pad;
    logic [63:0] int_aligned;
    logic [63:0] len_aligned;
    logic [71:0] int_content;
    logic [2:0]  n_arc;
    logic [31:0] arc;
    logic [34:0] arc_aligned;
    logic [5:0]  arc_shift;

    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign m_fire     = m_axis_tvalid && m_axis_tready;
    assign frm_done   = m_fire && m_axis_tlast;
    assign in_advance = in_valid_reg && ((enc_cnt == '0) || !frm_valid_reg || frm_done);
    assign frm_load   = in_advance && (enc_cnt != '0);

    assign s_axis_tready = !in_valid_reg || in_advance;
    assign m_axis_tvalid = frm_valid_reg;
    assign m_axis_tdata  = frm_bytes_reg[0];
    assign m_axis_tlast  = (frm_cnt_reg == 4'd1);

    assign arc = in_value_reg[31:0];

    always_comb
    begin
        n_uns = 4'd8;
        for (int n = 7; n >= 1; n--)
        begin
            if ((in_value_reg >> (8 * n)) == 64'd0)
            begin
                n_uns = 4'(n);
            end
        end
        n_sgn = 4'd8;
        for (int n = 7; n >= 1; n--)
        begin
            if (((in_value_reg >> (8 * n - 1)) == 64'd0) ||
                ((in_value_reg >> (8 * n - 1)) == (~64'd0 >> (8 * n - 1))))
            begin
                n_sgn = 4'(n);
            end
        end
        n_arc = 3'd1;
        for (int g = 1; g <= 4; g++)
        begin
            if ((arc >> (7 * g)) != 32'd0)
            begin
                n_arc = 3'(g + 1);
            end
        end
    end

    always_comb
    begin
        pad_probe   = in_value_reg >> (7'({n_uns, 3'b000}) - 7'd1);
        pad         = !in_signed_reg && pad_probe[0];
        n_int       = in_signed_reg ? n_sgn : n_uns;
        int_aligned = in_value_reg << (7'd64 - 7'({n_int, 3'b000}));
        len_aligned = in_value_reg << (7'd64 - 7'({n_uns, 3'b000}));
        int_content = pad ? {ZERO_BYTE, int_aligned} : {int_aligned, ZERO_BYTE};
        case (n_arc)
            3'd1:    arc_shift = 6'd28;
            3'd2:    arc_shift = 6'd21;
            3'd3:    arc_shift = 6'd14;
            3'd4:    arc_shift = 6'd7;
            default: arc_shift = 6'd0;
        endcase
        arc_aligned = {3'b000, arc} << arc_shift;
    end

    always_comb
    begin
        for (int k = 0; k < MaxBytes; k++)
        begin
            enc_bytes[k] = ZERO_BYTE;
        end
        enc_cnt = '0;
        unique case (in_op_reg)
            OP_INTEGER:
            begin
                enc_bytes[0] = TAG_INTEGER;
                enc_bytes[1] = 8'(n_int) + 8'(pad);
                for (int k = 0; k < 9; k++)
                begin
                    enc_bytes[k + 2] = int_content[71 - 8 * k -: 8];
                end
                enc_cnt = 4'd2 + n_int + 4'(pad);
            end
            OP_BOOLEAN:
            begin
                enc_bytes[0] = TAG_BOOLEAN;
                enc_bytes[1] = 8'h01;
                enc_bytes[2] = (in_value_reg != 64'd0) ? BOOL_TRUE : ZERO_BYTE;
                enc_cnt      = 4'd3;
            end
            OP_NULL:
            begin
                enc_bytes[0] = TAG_NULL;
                enc_bytes[1] = ZERO_BYTE;
                enc_cnt      = 4'd2;
            end
            OP_HEADER:
            begin
                enc_bytes[0] = in_tag_reg;
                if (in_value_reg < 64'h80)
                begin
                    enc_bytes[1] = in_value_reg[7:0];
                    enc_cnt      = 4'd2;
                end
                else
                begin
                    enc_bytes[1] = LONG_FORM | 8'(n_uns);
                    for (int k = 0; k < 8; k++)
                    begin
                        enc_bytes[k + 2] = len_aligned[63 - 8 * k -: 8];
                    end
                    enc_cnt = 4'd2 + n_uns;
                end
            end
            OP_OID_ARC:
            begin
                for (int k = 0; k < 5; k++)
                begin
                    enc_bytes[k] = {1'b0, arc_aligned[34 - 7 * k -: 7]} & SEVEN_MASK;
                    if (3'(k + 1) < n_arc)
                    begin
                        enc_bytes[k] = enc_bytes[k] | LONG_FORM;
                    end
                end
                enc_cnt = 4'(n_arc);
            end
            default:
            begin
                enc_cnt = '0;
            end
        endcase
    end

    always_comb
    begin
        frm_valid_next = frm_valid_reg;
        frm_cnt_next   = frm_cnt_reg;
        for (int k = 0; k < MaxBytes; k++)
        begin
            frm_bytes_next[k] = frm_bytes_reg[k];
        end
        if (frm_load)
        begin
            frm_valid_next = 1'b1;
            frm_cnt_next   = enc_cnt;
            for (int k = 0; k < MaxBytes; k++)
            begin
                frm_bytes_next[k] = enc_bytes[k];
            end
        end
        else if (m_fire)
        begin
            frm_valid_next = !m_axis_tlast;
            frm_cnt_next   = frm_cnt_reg - 4'd1;
            for (int k = 0; k < MaxBytes - 1; k++)
            begin
                frm_bytes_next[k] = frm_bytes_reg[k + 1];
            end
            frm_bytes_next[MaxBytes - 1] = ZERO_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            frm_valid_reg <= 1'b0;
            frm_cnt_reg   <= '0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (in_advance)
            begin
                in_valid_reg <= 1'b0;
            end
            frm_valid_reg <= frm_valid_next;
            frm_cnt_reg   <= frm_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_op_reg     <= s_axis_tuser[2:0];
            in_signed_reg <= s_axis_tuser[3];
            in_value_reg  <= s_axis_tdata[63:0];
            in_tag_reg    <= s_axis_tdata[71:64];
        end
        for (int k = 0; k < MaxBytes; k++)
        begin
            frm_bytes_reg[k] <= frm_bytes_next[k];
        end
    end

    // A held frame always has bytes left to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid_reg |-> (frm_cnt_reg != 4'd0) && (frm_cnt_reg <= 4'd11))
        else $error("frame byte count out of range");

    // The input register only stalls behind a frame that is still draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && frm_valid_reg)
        else $error("input stalled without a pending frame");

    // A byte that is not the last keeps the frame alive with one byte fewer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && !m_axis_tlast) |=>
            m_axis_tvalid && (frm_cnt_reg == $past(frm_cnt_reg) - 4'd1))
        else $error("frame lost bytes before its last transaction");

    // A frame ends after its last byte unless a new one is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (frm_done && !frm_load) |=> !frm_valid_reg)
        else $error("frame still valid after its last transaction");

    // A new frame is never loaded over one that still has bytes to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        frm_load |-> !frm_valid_reg || frm_done)
        else $error("frame overwritten while draining");

endmodule
